// ----- sv/assert_macros.svh -----
// assertion macros for the laplace solver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBL_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define RBL_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RBL_ASSERT_IMP(label, clk, rst_n, a, c)
`define RBL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- sv/rbl_pkg.sv -----
// ----------------------------------------------------------------------------
// rbl_pkg
// types and constants of the red-black laplace solver
// ----------------------------------------------------------------------------
`default_nettype none
package rbl_pkg;
  localparam int GRID_SIDE = 64;
  localparam int IDX_W = $clog2(GRID_SIDE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int SUM_W = 44;
  localparam int CFG_W = 40;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // five-point sum plus 5*2^31 is never negative and stays below 2^35
  localparam logic signed [35:0] DIV5_BIAS = 36'sd10737418240;
  // ceil(2^37 / 5): exact floor quotient for any 35-bit dividend
  localparam logic [34:0] DIV5_MUL = 35'd27487790695;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SOLVE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic REG_MAX_SWEEPS = 1'b0;
  localparam logic REG_CHANGE_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         sweeps_done;
    logic               converged;
    logic [SUM_W-1:0]   last_change;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_SW_START, S_CELL, S_NB, S_CALC, S_DIV, S_MUL, S_WB, S_SW_END,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- sv/rbl_ram.sv -----
// ----------------------------------------------------------------------------
// rbl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- sv/red_black_laplace_solver.sv -----
// ----------------------------------------------------------------------------
// red_black_laplace_solver
// red-black gauss-seidel relaxation of a square Q16.16 grid held in one ram
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | in_data (func,row,col,cell_value)
// out     | out | out_valid/out_stall | out_data (read_value,status)
// cfg     | in  | cfg_we              | cfg_index, cfg_wdata
// write: result in the next cycle; read: result via S_RD_WAIT (registered ram read)
// solve: per sweep each interior cell reads five entries through the single
//   ram port, divides by 5 with a reciprocal multiply (S_CALC, S_DIV, S_MUL),
//   writes back
// one item at a time; in_stall is high while an item is in work or its
//   result waits; reset is synchronous and clears control and status only
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module red_black_laplace_solver import rbl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);
  state_t state_r, state_nxt;
  logic [7:0] max_sw_r;
  logic [CFG_W-1:0] limit_r;
  logic [7:0] sweeps_r, sweeps_nxt;
  logic conv_r, conv_nxt;
  logic [SUM_W-1:0] chg_r, chg_nxt, acc_r, acc_nxt;
  logic signed [31:0] rv_r, rv_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, c_r, c_nxt;
  logic par_r, par_nxt;
  logic [2:0] nb_r, nb_nxt;
  logic signed [34:0] s_r, s_nxt;
  logic signed [31:0] old_r, old_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic signed [35:0] rem_r, rem_nxt;
  logic [52:0] prod_r, prod_nxt;
  logic we;
  logic [ADDR_W-1:0] addr;
  logic [31:0] wdata, rdata;

  rbl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sw_r <= 8'd20;
      limit_r <= CFG_W'(3221);
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_SWEEPS) max_sw_r <= cfg_wdata[7:0];
      else limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sweeps_r <= '0;
      conv_r <= 1'b0;
      chg_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweeps_r <= sweeps_nxt;
      conv_r <= conv_nxt;
      chg_r <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; rv_r <= rv_nxt; r_r <= r_nxt; c_r <= c_nxt;
    par_r <= par_nxt; nb_r <= nb_nxt; s_r <= s_nxt; old_r <= old_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; prod_r <= prod_nxt;
  end

  logic signed [31:0] nv;
  logic signed [32:0] d;
  logic [32:0] ad;
  logic [SUM_W:0] acc_sum;
  logic [IDX_W-1:0] nr, nc;
  logic [IDX_W:0] c2;
  logic [51:0] hi_prod;
  logic [69:0] prod_full;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = '{read_value: rv_r, sweeps_done: sweeps_r, converged: conv_r,
                      last_change: chg_r};

  always_comb begin
    state_nxt = state_r;
    sweeps_nxt = sweeps_r; conv_nxt = conv_r; chg_nxt = chg_r;
    acc_nxt = acc_r; rv_nxt = rv_r; r_nxt = r_r; c_nxt = c_r; par_nxt = par_r;
    nb_nxt = nb_r; s_nxt = s_r; old_nxt = old_r; q_nxt = q_r; rem_nxt = rem_r;
    prod_nxt = prod_r;
    we = 1'b0;
    addr = {r_r, c_r};
    wdata = q_r;
    nv = q_r;
    d = 33'(nv) - 33'(old_r);
    ad = d[32] ? 33'(-d) : 33'(d);
    acc_sum = (SUM_W+1)'(acc_r) + (SUM_W+1)'(ad);
    hi_prod = 52'(rem_r[34:18]) * 52'(DIV5_MUL);
    prod_full = {hi_prod, 18'd0} + 70'(prod_r);
    nr = r_r; nc = c_r;
    c2 = '0;
    case (state_r)
      S_IDLE: begin
        addr = {in_data.row, in_data.col};
        if (in_valid) begin
          rv_nxt = '0;
          case (in_data.func)
            FUNC_WRITE: begin
              we = 1'b1; wdata = in_data.cell_value;
              rv_nxt = in_data.cell_value; state_nxt = S_OUT;
            end
            FUNC_SOLVE: begin
              sweeps_nxt = '0; conv_nxt = 1'b0; chg_nxt = '0;
              state_nxt = (max_sw_r == 8'd0) ? S_OUT : S_SW_START;
            end
            FUNC_READ: state_nxt = S_RD_WAIT;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD_WAIT: begin
        rv_nxt = rdata; state_nxt = S_OUT;
      end
      S_SW_START: begin
        acc_nxt = '0; par_nxt = 1'b1;
        r_nxt = IDX_W'(1); c_nxt = IDX_W'(2);
        nb_nxt = '0; state_nxt = S_CELL;
      end
      S_CELL: begin
        // issue reads: self, left, right, up, down
        case (nb_r)
          3'd0: begin nr = r_r; nc = c_r; end
          3'd1: begin nr = r_r; nc = c_r - 1'b1; end
          3'd2: begin nr = r_r; nc = c_r + 1'b1; end
          3'd3: begin nr = r_r - 1'b1; nc = c_r; end
          default: begin nr = r_r + 1'b1; nc = c_r; end
        endcase
        addr = {nr, nc};
        if (nb_r != 3'd0) s_nxt = s_r + 35'(signed'(rdata));
        if (nb_r == 3'd1) old_nxt = rdata;
        if (nb_r == 3'd0) s_nxt = '0;
        nb_nxt = nb_r + 1'b1;
        if (nb_r == 3'd4) state_nxt = S_NB;
      end
      S_NB: begin
        s_nxt = s_r + 35'(signed'(rdata));
        state_nxt = S_CALC;
      end
      S_CALC: begin
        // offset to a nonnegative dividend so floor division is a plain multiply
        rem_nxt = 36'(s_r) + DIV5_BIAS;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        prod_nxt = 53'(rem_r[17:0]) * 53'(DIV5_MUL);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // quotient minus 2^31 is the quotient with its top bit flipped
        q_nxt = {~prod_full[68], prod_full[67:37]};
        state_nxt = S_WB;
      end
      S_WB: begin
        we = 1'b1; addr = {r_r, c_r};
        acc_nxt = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        nb_nxt = '0;
        c2 = {1'b0, c_r} + 2'd2;
        if (c2 >= (IDX_W+1)'(GRID_SIDE - 1)) begin
          r_nxt = r_r + 1'b1;
          c_nxt = ((r_r + 1'b1 + 1'b1) & 1'b1) == par_r ? IDX_W'(1) : IDX_W'(2);
          if (r_r == IDX_W'(GRID_SIDE - 2)) begin
            if (par_r) begin
              par_nxt = 1'b0; r_nxt = IDX_W'(1); c_nxt = IDX_W'(1);
              state_nxt = S_CELL;
            end else state_nxt = S_SW_END;
          end else state_nxt = S_CELL;
        end else begin
          c_nxt = c2[IDX_W-1:0]; state_nxt = S_CELL;
        end
      end
      S_SW_END: begin
        sweeps_nxt = sweeps_r + 1'b1; chg_nxt = acc_r;
        if (acc_r < SUM_W'(limit_r)) begin
          conv_nxt = 1'b1; state_nxt = S_OUT;
        end else if (sweeps_r + 1'b1 == max_sw_r) state_nxt = S_OUT;
        else state_nxt = S_SW_START;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  `RBL_ASSERT_IMP(a_stall_busy, clk, rst_n, out_valid, in_stall)
  `RBL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `RBL_ASSERT_IMP(a_conv_swept, clk, rst_n, out_valid && conv_r, sweeps_r != 8'd0)
endmodule
`default_nettype wire
